FILE: hw/rtl/pkcr_pkg.sv
// shared types and constants for the palette key color remap block
`default_nettype none

package pkcr_pkg;

    // default palette depth
    localparam int DEF_PALETTE_SLOTS = 64;

    // lanes per priority group
    localparam int GRP_LANES = 8;
    localparam int LANE_W    = 3;

    // field widths
    localparam int SLOT_W    = 6;
    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int ENTRIES_W = 7;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic {
        REG_PALETTE_ENTRIES = 1'b0,
        REG_UNUSED          = 1'b1
    } reg_idx_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } req_t;

    // one item as it travels down the pipeline
    typedef struct packed {
        req_t              req;
        logic [SLOT_W-1:0] slot;
        logic [RGB_W-1:0]  rgb;
        logic [CHAN_W-1:0] alpha;
        logic [RGB_W-1:0]  tgt;
    } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pkcr_search.sv
// key store, parallel key compare and two-level priority pick
`default_nettype none

module pkcr_search #(
    parameter int PALETTE_SLOTS = pkcr_pkg::DEF_PALETTE_SLOTS,
    parameter int IDX_W         = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic                           in_valid,
    input  wire pkcr_pkg::item_t                in_item,
    input  wire logic [pkcr_pkg::ENTRIES_W-1:0] entries,
    output logic                                v3,
    output pkcr_pkg::item_t                     item3,
    output logic                                hit,
    output logic [IDX_W-1:0]                    idx
);
    import pkcr_pkg::*;

    localparam int NGRP = (PALETTE_SLOTS + GRP_LANES - 1) / GRP_LANES;
    localparam int GI_W = (NGRP > 1) ? $clog2(NGRP) : 1;

    // stage registers
    logic  v1_reg, v2_reg, v3_reg;
    item_t item1_reg, item2_reg, item3_reg;

    // key store
    logic [RGB_W-1:0]         key_reg [PALETTE_SLOTS];
    logic [PALETTE_SLOTS-1:0] usable_reg;

    // compare stage
    logic [NGRP-1:0][GRP_LANES-1:0] match_next;
    logic [NGRP-1:0][GRP_LANES-1:0] match_reg;

    // group stage
    logic [NGRP-1:0]             ghit_next, ghit_reg;
    logic [NGRP-1:0][LANE_W-1:0] glane_next, glane_reg;

    // key write
    logic                  key_wr;
    logic [IDX_W+SLOT_W-1:0] slot_wide;
    logic [IDX_W-1:0]      widx;

    // final pick
    logic [GI_W-1:0]       gsel;
    logic [LANE_W-1:0]     lsel;
    logic [GI_W+LANE_W-1:0] idx_full;

    assign slot_wide = {{IDX_W{1'b0}}, item1_reg.slot};
    assign widx      = slot_wide[IDX_W-1:0];
    assign key_wr    = adv && v1_reg && (item1_reg.req == REQ_LOAD)
                       && (int'(item1_reg.slot) < PALETTE_SLOTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item1_reg  <= in_item;
            item2_reg  <= item1_reg;
            item3_reg  <= item2_reg;
            match_reg  <= match_next;
            ghit_reg   <= ghit_next;
            glane_reg  <= glane_next;
        end
    end

    // loads update the keys as they leave the compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usable_reg <= '0;
        end else if (key_wr) begin
            usable_reg[widx] <= (item1_reg.alpha != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_reg[widx] <= item1_reg.rgb;
        end
    end

    // one comparator per slot
    for (genvar k = 0; k < NGRP * GRP_LANES; k++) begin : g_cmp
        if (k < PALETTE_SLOTS) begin : g_live
            assign match_next[k / GRP_LANES][k % GRP_LANES] =
                usable_reg[k] && (key_reg[k] == item1_reg.rgb)
                && (k < int'(entries));
        end else begin : g_pad
            assign match_next[k / GRP_LANES][k % GRP_LANES] = 1'b0;
        end
    end

    // lowest set lane within each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            ghit_next[g]  = |match_reg[g];
            glane_next[g] = '0;
            for (int l = GRP_LANES - 1; l >= 0; l--) begin
                if (match_reg[g][l]) begin
                    glane_next[g] = LANE_W'(l);
                end
            end
        end
    end

    // lowest hitting group
    always_comb begin
        hit  = 1'b0;
        gsel = '0;
        lsel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (ghit_reg[g]) begin
                hit  = 1'b1;
                gsel = GI_W'(g);
                lsel = glane_reg[g];
            end
        end
    end

    assign idx_full = {gsel, lsel};
    assign idx      = idx_full[IDX_W-1:0];
    assign v3       = v3_reg;
    assign item3    = item3_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/palette_key_color_remap_top.sv
// top level of the palette key color remap block
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata (load or pixel), s_tuser (req_type)
//  m_*       out  m_tvalid / m_tready       m_tdata (rgba out), m_tuser (matched)
//  apb       in   psel / penable / pready   paddr, pwdata, pwrite -> prdata
//
// one item per cycle sustained while m_tready keeps the output moving; a pixel passes
// the input register, compare register and group pick register, then final pick plus
// target memory read into the output register
// load items move down the same pipeline and produce no output item
// reset clears valid bits, slot usable bits and palette_entries; no clearing pass
// m_tready low with a pending output freezes every stage and drops s_tready
`default_nettype none

module palette_key_color_remap_top #(
    parameter int PALETTE_SLOTS = pkcr_pkg::DEF_PALETTE_SLOTS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // slot[5:0], red[13:6], green[21:14], blue[29:22], alpha[37:30],
    // target_red[45:38], target_green[53:46], target_blue[61:54], zero pad
    input  wire logic [pkcr_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic                           s_tuser,
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [pkcr_pkg::M_TDATA_W-1:0]      m_tdata,
    // matched[0]
    output logic                                m_tuser,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pkcr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pkcr_pkg::PDATA_W-1:0]   pwdata,
    output logic [pkcr_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import pkcr_pkg::*;

    localparam int IDX_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;

    // configuration
    logic [ENTRIES_W-1:0] entries_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    // pipeline control
    logic  adv;
    item_t in_item;

    // search results for the item in stage 3
    logic             v3;
    item_t            item3;
    logic             hit3;
    logic [IDX_W-1:0] idx3;

    // target memory
    logic [RGB_W-1:0]          tgt_mem [PALETTE_SLOTS];
    logic                      tgt_wr;
    logic [IDX_W+SLOT_W-1:0]   slot_wide;
    logic [IDX_W-1:0]          widx;

    // output register
    logic              v4_reg, v4_next;
    logic [RGB_W-1:0]  rgb4_reg;
    logic [CHAN_W-1:0] alpha4_reg;
    logic              hit4_reg;
    logic [RGB_W-1:0]  tgt_rd_reg;
    logic [RGB_W-1:0]  rgb_out;

    // apb register
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
        end else if (cfg_wr && (reg_idx == REG_PALETTE_ENTRIES)) begin
            entries_reg <= pwdata[ENTRIES_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PALETTE_ENTRIES: prdata = {{(PDATA_W - ENTRIES_W){1'b0}}, entries_reg};
            default:             prdata = '0;
        endcase
    end

    // whole pipeline moves unless a finished pixel waits
    assign adv      = !v4_reg || m_tready;
    assign s_tready = adv;

    // unpack the input item
    assign in_item.req   = req_t'(s_tuser);
    assign in_item.slot  = s_tdata[5:0];
    assign in_item.rgb   = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};
    assign in_item.alpha = s_tdata[37:30];
    assign in_item.tgt   = {s_tdata[45:38], s_tdata[53:46], s_tdata[61:54]};

    pkcr_search #(
        .PALETTE_SLOTS (PALETTE_SLOTS),
        .IDX_W         (IDX_W)
    ) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .entries  (entries_reg),
        .v3       (v3),
        .item3    (item3),
        .hit      (hit3),
        .idx      (idx3)
    );

    // targets are written at the stage where pixels read them, keeping item order
    assign slot_wide = {{IDX_W{1'b0}}, item3.slot};
    assign widx      = slot_wide[IDX_W-1:0];
    assign tgt_wr    = adv && v3 && (item3.req == REQ_LOAD)
                       && (int'(item3.slot) < PALETTE_SLOTS);

    always_ff @(posedge aclk) begin
        if (tgt_wr) begin
            tgt_mem[widx] <= item3.tgt;
        end
        if (adv) begin
            tgt_rd_reg <= tgt_mem[idx3];
        end
    end

    // output register
    assign v4_next = v3 && (item3.req == REQ_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rgb4_reg   <= item3.rgb;
            alpha4_reg <= item3.alpha;
            hit4_reg   <= hit3;
        end
    end

    assign rgb_out  = hit4_reg ? tgt_rd_reg : rgb4_reg;
    assign m_tvalid = v4_reg;
    assign m_tdata  = {alpha4_reg, rgb_out[7:0], rgb_out[15:8], rgb_out[23:16]};
    assign m_tuser  = hit4_reg;

`ifndef SYNTHESIS
    // a match needs a nonzero palette_entries
    a_hit_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> entries_reg != '0)
        else $error("matched output with no palette entries");

    // picked slot lies within the searched range
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3 && hit3 |-> int'(idx3) < int'(entries_reg))
        else $error("matched slot beyond palette_entries");

    // an empty output never backs up the input
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled pipeline leaves the key search result untouched
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(hit3) && $stable(v3))
        else $error("search stage changed during stall");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_palette_key_color_remap_top.sv
// testbench for the palette key color remap block: directed and random items checked in order
`default_nettype none

module tb_palette_key_color_remap_top;
    import pkcr_pkg::*;

    localparam int SLOTS        = DEF_PALETTE_SLOTS;
    // pipeline is four stages deep, leave some margin before touching the register
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 200;
    localparam int RAND_PHASES  = 6;

    // one input item, fields as the block sees them
    typedef struct packed {
        req_t       req;
        logic [5:0] slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] tgt_red;
        logic [7:0] tgt_green;
        logic [7:0] tgt_blue;
    } remap_item_t;

    // one recolored pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       matched;
    } pixel_out_t;

    // clock, reset and block ports; every input known from time zero
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    // slot[5:0], red[13:6], green[21:14], blue[29:22], alpha[37:30],
    // target_red[45:38], target_green[53:46], target_blue[61:54], zero pad
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // req_type[0]
    logic                 s_tuser  = 1'b0;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    wire [M_TDATA_W-1:0]  m_tdata;
    // matched[0]
    wire                  m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    wire [PDATA_W-1:0]    prdata;
    wire                  pready;

    // shadow palette, updated in acceptance order
    logic [RGB_W-1:0]     key_mem  [SLOTS];
    logic [RGB_W-1:0]     tgt_mem  [SLOTS];
    logic                 live_mem [SLOTS];
    logic [ENTRIES_W-1:0] entries_cfg = '0;

    remap_item_t feed_q [$];     // items waiting for the driver
    pixel_out_t  owed_q [$];     // recolored pixels still to come out
    int          queued_count = 0;
    int          taken_count  = 0;
    int          err_count    = 0;

    // idle knobs, changed per phase by the stimulus
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    int          send_wait      = 0;
    int          recv_wait      = 0;
    logic        s_took         = 1'b0;
    logic        m_took         = 1'b0;

    palette_key_color_remap_top #(
        .PALETTE_SLOTS (SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 unit clock period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // apply one accepted item to the shadow palette, queue the pixel it should produce
    function automatic void recolor_pixel(input remap_item_t it);
        logic [RGB_W-1:0] rgb;
        pixel_out_t       res;
        int               lim;
        rgb = {it.red, it.green, it.blue};
        if (it.req == REQ_LOAD) begin
            key_mem[it.slot]  = rgb;
            tgt_mem[it.slot]  = {it.tgt_red, it.tgt_green, it.tgt_blue};
            live_mem[it.slot] = (it.alpha != 8'd0);
        end else begin
            // search stops at the palette depth even for larger register values
            lim = (entries_cfg > SLOTS) ? SLOTS : int'(entries_cfg);
            res = '{red: it.red, green: it.green, blue: it.blue, alpha: it.alpha,
                    matched: 1'b0};
            // lowest usable slot with the same key wins
            for (int k = 0; k < lim; k++) begin
                if (!res.matched && live_mem[k] && key_mem[k] == rgb) begin
                    {res.red, res.green, res.blue} = tgt_mem[k];
                    res.matched = 1'b1;
                end
            end
            owed_q = {owed_q, res};
        end
    endfunction

    // monitor: input acceptance feeds the shadow palette, output items are checked in order
    always @(posedge aclk) begin
        remap_item_t seen;
        pixel_out_t  got;
        pixel_out_t  want;
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            m_took <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16],
                        alpha: m_tdata[31:24], matched: m_tuser};
                if (owed_q.size() == 0) begin
                    flag_mismatch($sformatf("pixel %h matched %b with none pending",
                                            m_tdata, m_tuser));
                end else begin
                    want = owed_q.pop_front();
                    if (got.red !== want.red)
                        flag_mismatch($sformatf("out_red %h, want %h", got.red, want.red));
                    if (got.green !== want.green)
                        flag_mismatch($sformatf("out_green %h, want %h", got.green, want.green));
                    if (got.blue !== want.blue)
                        flag_mismatch($sformatf("out_blue %h, want %h", got.blue, want.blue));
                    if (got.alpha !== want.alpha)
                        flag_mismatch($sformatf("out_alpha %h, want %h", got.alpha, want.alpha));
                    if (got.matched !== want.matched)
                        flag_mismatch($sformatf("matched %b, want %b", got.matched,
                                                want.matched));
                end
            end
            if (s_tvalid && s_tready) begin
                seen.req       = req_t'(s_tuser);
                seen.slot      = s_tdata[5:0];
                seen.red       = s_tdata[13:6];
                seen.green     = s_tdata[21:14];
                seen.blue      = s_tdata[29:22];
                seen.alpha     = s_tdata[37:30];
                seen.tgt_red   = s_tdata[45:38];
                seen.tgt_green = s_tdata[53:46];
                seen.tgt_blue  = s_tdata[61:54];
                recolor_pixel(seen);
                taken_count++;
            end
        end
    end

    // driver: holds an item until it is taken, then idles a drawn number of cycles
    always @(negedge aclk) begin
        logic        nxt_valid;
        remap_item_t it;
        nxt_valid = s_tvalid && !s_took;
        if (aresetn && !nxt_valid) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (feed_q.size() > 0) begin
                it = feed_q.pop_front();
                s_tdata <= {2'b00, it.tgt_blue, it.tgt_green, it.tgt_red, it.alpha,
                            it.blue, it.green, it.red, it.slot};
                s_tuser <= it.req;
                nxt_valid = 1'b1;
                send_wait = sender_idles ? $urandom_range(0, 6) : 0;
            end
        end
        s_tvalid <= nxt_valid;
    end

    // receiver: stalls a drawn number of cycles after each output item
    always @(negedge aclk) begin
        if (m_took) begin
            recv_wait = receiver_idles ? $urandom_range(0, 6) : 0;
        end
        if (recv_wait > 0) begin
            recv_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one apb transfer to palette_entries; a read compares with the shadow value
    task automatic apb_cycle(input logic wr, input logic [ENTRIES_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_PALETTE_ENTRIES, 2'b00};
        pwdata  <= {{(PDATA_W-ENTRIES_W){1'b0}}, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!wr && prdata[ENTRIES_W-1:0] !== entries_cfg) begin
            flag_mismatch($sformatf("palette_entries reads %h, want %h",
                                    prdata[ENTRIES_W-1:0], entries_cfg));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_entries(input logic [ENTRIES_W-1:0] val);
        apb_cycle(1'b1, val);
        entries_cfg = val;
        apb_cycle(1'b0, '0);
    endtask

    // wait until every item is taken and every pixel is out, then let the pipe empty
    task automatic settle();
        do @(negedge aclk);
        while (taken_count != queued_count || owed_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_load(input logic [5:0] slot, input logic [RGB_W-1:0] key,
                             input logic [7:0] alpha, input logic [RGB_W-1:0] tgt);
        remap_item_t it;
        it = '{req: REQ_LOAD, slot: slot, red: key[23:16], green: key[15:8],
               blue: key[7:0], alpha: alpha, tgt_red: tgt[23:16],
               tgt_green: tgt[15:8], tgt_blue: tgt[7:0]};
        feed_q = {feed_q, it};
        queued_count++;
    endtask

    // slot and target fields mean nothing for a pixel, so they carry noise
    task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic [7:0] alpha);
        logic [RGB_W-1:0] noise;
        remap_item_t      it;
        noise = 24'($urandom);
        it = '{req: REQ_PIXEL, slot: 6'($urandom_range(0, 63)),
               red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
               alpha: alpha, tgt_red: noise[23:16], tgt_green: noise[15:8],
               tgt_blue: noise[7:0]};
        feed_q = {feed_q, it};
        queued_count++;
    endtask

    initial begin
        logic [RGB_W-1:0]     pool [16];
        logic [ENTRIES_W-1:0] phase_entries [RAND_PHASES];
        int                   hi_slot;
        logic [5:0]           slot;
        logic [7:0]           alpha;

        for (int k = 0; k < SLOTS; k++) begin
            key_mem[k]  = '0;
            tgt_mem[k]  = '0;
            live_mem[k] = 1'b0;
        end

        // reset held low from time zero, released on a falling edge
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // register comes out of reset at zero
        apb_cycle(1'b0, '0);

        // no slots searched: everything passes through, even a loaded key
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_pixel(24'h000000, 8'h00);
        send_pixel(24'hffffff, 8'hff);
        send_load(6'd0, 24'hffffff, 8'hff, 24'h000000);
        send_pixel(24'hffffff, 8'h80);
        settle();

        // full palette: hits, a disabled key, duplicate keys, target reload
        program_entries(7'd64);
        send_pixel(24'hffffff, 8'h7f);
        send_load(6'd63, 24'h000000, 8'h01, 24'hffffff);
        // pixel right behind the load of the slot it needs
        send_pixel(24'h000000, 8'h00);
        send_load(6'd5, 24'h123456, 8'h00, 24'habcdef);
        send_pixel(24'h123456, 8'h5a);
        send_load(6'd10, 24'ha5a5a5, 8'hff, 24'h111111);
        send_load(6'd20, 24'ha5a5a5, 8'h80, 24'h222222);
        send_pixel(24'ha5a5a5, 8'hc3);
        // disabling the lower duplicate hands the key to the next one
        send_load(6'd10, 24'ha5a5a5, 8'h00, 24'h333333);
        send_pixel(24'ha5a5a5, 8'h3c);
        send_pixel(24'ha5a5a4, 8'h01);
        send_load(6'd0, 24'hffffff, 8'hff, 24'h55aa55);
        send_pixel(24'hffffff, 8'hff);
        settle();

        // register above the palette depth still searches every slot
        program_entries(7'd127);
        send_pixel(24'h000000, 8'h11);
        settle();

        // top slot left out of the search
        program_entries(7'd63);
        send_pixel(24'h000000, 8'h22);
        send_pixel(24'ha5a5a5, 8'h33);
        settle();

        // only slot 0 searched
        program_entries(7'd1);
        send_pixel(24'hffffff, 8'h44);
        send_pixel(24'ha5a5a5, 8'h55);
        settle();

        // random part: keys from a small pool so that pixels hit and keys repeat
        for (int k = 0; k < 16; k++) begin
            pool[k] = 24'($urandom);
        end
        phase_entries[0] = 7'd64;
        phase_entries[1] = 7'd0;
        phase_entries[2] = 7'd127;
        phase_entries[3] = 7'($urandom_range(2, 62));
        phase_entries[4] = 7'd64;
        phase_entries[5] = 7'($urandom_range(0, 64));

        for (int p = 0; p < RAND_PHASES; p++) begin
            program_entries(phase_entries[p]);
            // rotate through busy and quiet sides so some stretches run back to back
            sender_idles   = (p % 4 == 0) || (p % 4 == 2);
            receiver_idles = (p % 4 == 0) || (p % 4 == 1);
            hi_slot = (phase_entries[p] == 0) ? 0 :
                      (phase_entries[p] > SLOTS) ? SLOTS - 1 : phase_entries[p] - 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // loads lean toward searched slots, some disable their slot
                    slot  = $urandom_range(0, 1) ? 6'($urandom_range(0, hi_slot))
                                                 : 6'($urandom_range(0, 63));
                    alpha = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                    send_load(slot,
                              ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                          : pool[$urandom_range(0, 15)],
                              alpha, 24'($urandom));
                end else begin
                    send_pixel(($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                           : pool[$urandom_range(0, 15)],
                               8'($urandom_range(0, 255)));
                end
            end
            // sender holds off until every pixel of the phase is out
            settle();
        end

        if (err_count == 0) begin
            $display("tb_palette_key_color_remap_top: done, clean");
        end else begin
            $display("tb_palette_key_color_remap_top: done, errors");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("tb_palette_key_color_remap_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
